/* rtl/sukt_pkg.sv */
// Package for the sorted unique key table: sizes, action and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package sukt_pkg;

  // Table size and field widths.
  localparam int CAPACITY    = 64;
  localparam int KEY_W       = 34;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 6;
  localparam int COUNT_W     = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Requested action of one input item.
  typedef enum logic [1:0] {
    ACT_SEARCH = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Outcome reported with each result.
  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_DUPLICATE = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the item and its compare results.
    logic update;   // Apply the action and load the result register.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // Result register holds a result that is not taken.
  } dp_status_t;

endpackage

/* rtl/sukt_ctrl.sv */
// Controller of the sorted unique key table: a two-state machine that captures
// one item, then applies it once the result register can take the result.
// Depends on sukt_pkg.
module sukt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  sukt_pkg::dp_status_t dp_status,
  output sukt_pkg::cmd_t       cmd
);

  sukt_pkg::state_t state_r;
  sukt_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sukt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      sukt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = sukt_pkg::ST_UPDATE;
        end
      end
      sukt_pkg::ST_UPDATE: begin
        if (!dp_status.out_blocked) begin
          cmd.update = 1'b1;
          state_nxt  = sukt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sukt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sukt_datapath.sv */
// Datapath of the sorted unique key table: the register table with one compare
// per slot, the shift network for insert and remove, and the result register.
// Depends on sukt_pkg.
module sukt_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sukt_pkg::action_t             in_action,
  input  logic [sukt_pkg::KEY_W-1:0]    in_key,
  input  sukt_pkg::cmd_t                cmd,
  output sukt_pkg::dp_status_t          dp_status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sukt_pkg::status_t             out_status,
  output logic [sukt_pkg::POS_W-1:0]    out_position,
  output logic [sukt_pkg::COUNT_W-1:0]  out_count
);

  localparam int CAP = sukt_pkg::CAPACITY;

  // Table storage; slots at and above the count are never looked at.
  logic [sukt_pkg::KEY_W-1:0] entries_r [CAP];
  logic [sukt_pkg::CNT_W-1:0] count_r;
  logic [sukt_pkg::CNT_W-1:0] count_nxt;

  // Captured item and compare results.
  sukt_pkg::action_t          action_r;
  logic [sukt_pkg::KEY_W-1:0] key_r;
  logic [CAP-1:0]             lt_r;
  logic                       hit_r;
  logic [CAP-1:0]             lt;
  logic [CAP-1:0]             eq;

  // Result register.
  logic                         out_valid_r;
  sukt_pkg::status_t            out_status_r;
  logic [sukt_pkg::POS_W-1:0]   out_position_r;
  logic [sukt_pkg::COUNT_W-1:0] out_count_r;

  // Decoded update.
  logic [sukt_pkg::CNT_W-1:0] pos;
  logic                       full;
  logic                       do_insert;
  logic                       do_remove;
  sukt_pkg::status_t          status_nxt;
  logic [sukt_pkg::CNT_W-1:0] position_nxt;

  // One compare per slot against the incoming key. Since the table is sorted,
  // the less-than vector is a thermometer code ending at the insertion point.
  for (genvar i = 0; i < CAP; i++) begin : g_cmp
    localparam logic [sukt_pkg::CNT_W-1:0] SlotIdx = sukt_pkg::CNT_W'(i);
    logic slot_used;
    assign slot_used = (SlotIdx < count_r);
    assign lt[i]     = slot_used && (entries_r[i] < in_key);
    assign eq[i]     = slot_used && (entries_r[i] == in_key);
  end

  // Capture the item with its compare results.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      key_r    <= in_key;
      lt_r     <= lt;
      hit_r    <= |eq;
    end
  end

  // Insertion point: number of used slots below the key.
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAP; i++) begin
      if (lt_r[i]) begin
        pos = sukt_pkg::CNT_W'(i + 1);
      end
    end
  end

  assign full = (count_r >= sukt_pkg::CNT_W'(CAP));

  // Decode the action into result fields and table changes.
  always_comb begin
    status_nxt   = sukt_pkg::STS_DONE;
    position_nxt = '0;
    count_nxt    = count_r;
    do_insert    = 1'b0;
    do_remove    = 1'b0;
    case (action_r)
      sukt_pkg::ACT_SEARCH: begin
        if (hit_r) begin
          position_nxt = pos;
        end else begin
          status_nxt = sukt_pkg::STS_NOT_FOUND;
        end
      end
      sukt_pkg::ACT_INSERT: begin
        if (hit_r) begin
          status_nxt   = sukt_pkg::STS_DUPLICATE;
          position_nxt = pos;
        end else if (full) begin
          status_nxt = sukt_pkg::STS_FULL;
        end else begin
          do_insert    = 1'b1;
          position_nxt = pos;
          count_nxt    = count_r + 1'b1;
        end
      end
      sukt_pkg::ACT_REMOVE: begin
        if (hit_r) begin
          do_remove    = 1'b1;
          position_nxt = pos;
          count_nxt    = count_r - 1'b1;
        end else begin
          status_nxt = sukt_pkg::STS_NOT_FOUND;
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  // Shift network. On insert, slots at or above the insertion point take their
  // lower neighbor and the insertion slot takes the key. On remove, slots at or
  // above the removed key take their upper neighbor.
  for (genvar i = 0; i < CAP; i++) begin : g_slot
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.update && !lt_r[i]) begin
          if (do_insert) begin
            entries_r[i] <= key_r;
          end else if (do_remove) begin
            entries_r[i] <= entries_r[i+1];
          end
        end
      end
    end else if (i == CAP - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.update && do_insert && !lt_r[i]) begin
          entries_r[i] <= lt_r[i-1] ? key_r : entries_r[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.update && !lt_r[i]) begin
          if (do_insert) begin
            entries_r[i] <= lt_r[i-1] ? key_r : entries_r[i-1];
          end else if (do_remove) begin
            entries_r[i] <= entries_r[i+1];
          end
        end
      end
    end
  end

  // Result register: loaded on update, emptied when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status_r   <= status_nxt;
      out_position_r <= sukt_pkg::POS_W'(position_nxt);
      out_count_r    <= sukt_pkg::COUNT_W'(count_nxt);
    end
  end

  assign dp_status.out_blocked = out_valid_r && !out_ready;
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_position          = out_position_r;
  assign out_count             = out_count_r;

endmodule

/* rtl/sorted_unique_key_table_top.sv */
// Top level of the sorted unique key table: stream ports, field packing,
// and the controller and datapath. Depends on sukt_pkg, sukt_ctrl, sukt_datapath.
//
//   Channel  Direction  Payload
//   in_      slave      tuser: action; tdata: key
//   out_     master     tuser: status; tdata: position, count
//
// Each item is accepted in the idle state, where every slot compares against
// its key; the update state then shifts the table and loads the result register.
// A result waiting to be taken does not stop the next item from being accepted;
// it only holds the update of that next item until the result is taken.
// Reset is synchronous and active low and empties the table at once.
module sorted_unique_key_table_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sukt_pkg::IN_TDATA_W-1:0]      in_tdata,   // [33:0] key
  input  logic [1:0]                           in_tuser,   // [1:0] action
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sukt_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [5:0] position, [12:6] count
  output logic [1:0]                           out_tuser   // [1:0] status
);

  sukt_pkg::cmd_t                 cmd;
  sukt_pkg::dp_status_t           dp_status;
  sukt_pkg::status_t              out_status;
  logic [sukt_pkg::POS_W-1:0]     out_position;
  logic [sukt_pkg::COUNT_W-1:0]   out_count;

  // Controller.
  sukt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // Datapath.
  sukt_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_action    (sukt_pkg::action_t'(in_tuser)),
    .in_key       (in_tdata[sukt_pkg::KEY_W-1:0]),
    .cmd          (cmd),
    .dp_status    (dp_status),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

  // Result packing, zero padded to whole bytes.
  assign out_tdata = {{(sukt_pkg::OUT_TDATA_W - sukt_pkg::POS_W - sukt_pkg::COUNT_W){1'b0}},
                      out_count, out_position};
  assign out_tuser = out_status;

endmodule

/* sim/tb_sorted_unique_key_table_top.sv */
`timescale 1ns / 1ps
// Testbench for sorted_unique_key_table_top: directed and random search, insert,
// remove and clear streams checked against a local table predictor.
// Depends on sukt_pkg and the RTL of sorted_unique_key_table_top.
module tb_sorted_unique_key_table_top;
  import sukt_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MIX_FILL     = 0;
  localparam int MIX_DRAIN    = 1;
  localparam int MIX_BALANCED = 2;

  typedef struct {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  // Keeps a shadow of the sorted table and the results it implies.
  class key_table_scoreboard;
    logic [KEY_W-1:0] keys [CAPACITY];
    int               held;
    int               failures;
    table_result_t    expected_results [$];

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Applies one accepted action to the shadow table and queues its result.
    function void apply_action(action_t act, logic [KEY_W-1:0] key);
      int            slot;
      bit            hit;
      table_result_t res;
      slot = 0;
      while (slot < held && keys[slot] < key) slot++;
      hit = (slot < held) && (keys[slot] == key);
      res.status   = STS_DONE;
      res.position = '0;
      case (act)
        ACT_SEARCH: begin
          if (hit) res.position = slot[POS_W-1:0];
          else res.status = STS_NOT_FOUND;
        end
        ACT_INSERT: begin
          if (hit) begin
            res.status   = STS_DUPLICATE;
            res.position = slot[POS_W-1:0];
          end else if (held >= CAPACITY) begin
            res.status = STS_FULL;
          end else begin
            for (int j = held; j > slot; j--) keys[j] = keys[j-1];
            keys[slot]   = key;
            held++;
            res.position = slot[POS_W-1:0];
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            for (int j = slot + 1; j < held; j++) keys[j-1] = keys[j];
            held--;
            res.position = slot[POS_W-1:0];
          end else begin
            res.status = STS_NOT_FOUND;
          end
        end
        default: held = 0;
      endcase
      res.count = held[COUNT_W-1:0];
      expected_results.push_back(res);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void compare_result(status_t status, logic [POS_W-1:0] position,
                                 logic [COUNT_W-1:0] count);
      table_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d position %0d count %0d",
               status, position, count);
        failures++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
        failures++;
      end
      if (position !== exp_res.position) begin
        $error("position mismatch: expected %0d, actual %0d", exp_res.position, position);
        failures++;
      end
      if (count !== exp_res.count) begin
        $error("count mismatch: expected %0d, actual %0d", exp_res.count, count);
        failures++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [33:0] key
  logic [1:0]             in_tuser;   // [1:0] action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [5:0] position, [12:6] count
  logic [1:0]             out_tuser;  // [1:0] status

  key_table_scoreboard sb;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  cycles;

  sorted_unique_key_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver stalls at random; inputs change on the falling edge only.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.compare_result(status_t'(out_tuser), out_tdata[5:0], out_tdata[12:6]);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_unique_key_table_top: FAIL");
      $finish;
    end
  end

  // Offers one item, with random sender gaps, and waits for its transfer.
  task automatic send_item(input action_t act, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {{(IN_TDATA_W-KEY_W){1'b0}}, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_action(act, key);
    @(negedge clk);
  endtask

  // Holds the input back until every expected result has been taken.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic action_t pick_action(int mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  return (r < 75) ? ACT_INSERT : (r < 88) ? ACT_SEARCH : ACT_REMOVE;
      MIX_DRAIN: return (r < 55) ? ACT_REMOVE : (r < 75) ? ACT_SEARCH :
                        (r < 97) ? ACT_INSERT : ACT_CLEAR;
      default:   return (r < 35) ? ACT_INSERT : (r < 65) ? ACT_SEARCH :
                        (r < 97) ? ACT_REMOVE : ACT_CLEAR;
    endcase
  endfunction

  // Held keys make hits likely; a narrow range makes near misses; the rest
  // spreads over all 34 bits.
  function automatic logic [KEY_W-1:0] pick_key(action_t act);
    int r;
    r = $urandom_range(99);
    if (sb.held > 0 && r < ((act == ACT_INSERT) ? 15 : 60))
      return sb.keys[$urandom_range(sb.held - 1)];
    if (r < 75)
      return KEY_W'($urandom_range(300));
    return {2'($urandom_range(3)), 32'($urandom())};
  endfunction

  task automatic run_random(input int n_items);
    int      mix;
    int      left_in_mix;
    action_t act;
    left_in_mix = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left_in_mix == 0) begin
        mix         = $urandom_range(2);
        left_in_mix = $urandom_range(40, 160);
      end
      left_in_mix--;
      if (i == n_items / 2) wait_drained();
      act = pick_action(mix);
      send_item(act, pick_key(act));
    end
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = ACT_SEARCH;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, key extremes, duplicates, removes at each end, clear.
    send_item(ACT_SEARCH, '0);
    send_item(ACT_REMOVE, 34'd5);
    send_item(ACT_CLEAR,  34'd77);
    send_item(ACT_INSERT, {KEY_W{1'b1}});
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, 34'd9999999999);
    send_item(ACT_INSERT, 34'd1234567890);
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, {KEY_W{1'b1}});
    send_item(ACT_SEARCH, {KEY_W{1'b1}});
    send_item(ACT_SEARCH, 34'd42);
    send_item(ACT_INSERT, 34'h2AAAAAAAA);
    send_item(ACT_INSERT, 34'h155555555);
    send_item(ACT_REMOVE, 34'd9999999999);
    send_item(ACT_REMOVE, '0);
    send_item(ACT_REMOVE, {KEY_W{1'b1}});
    send_item(ACT_REMOVE, '0);
    send_item(ACT_SEARCH, 34'h155555555);
    send_item(ACT_CLEAR,  {KEY_W{1'b1}});
    send_item(ACT_SEARCH, 34'd1234567890);
    send_item(ACT_INSERT, 34'd1234567890);

    // Random: the receiver idles more, then the sender, then neither.
    send_idle_pct = 38;
    recv_idle_pct = 52;
    run_random(RANDOM_ITEMS / 3);
    wait_drained();
    send_idle_pct = 52;
    recv_idle_pct = 38;
    run_random(RANDOM_ITEMS / 3);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_sorted_unique_key_table_top: PASS");
    end else begin
      $display("tb_sorted_unique_key_table_top: FAIL");
    end
    $finish;
  end

endmodule
